// ===== design/waypoint_follow_guidance_macros.svh =====
// assertion helpers shared by the guidance block
`ifndef WAYPOINT_FOLLOW_GUIDANCE_MACROS_SVH
`define WAYPOINT_FOLLOW_GUIDANCE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WFG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WFG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wfg_pkg.sv =====
package wfg_pkg;

  // field widths
  localparam int COORD_W  = 24;
  localparam int CFG_W    = 23;
  localparam int COUNT_W  = 5;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 8;

  // configuration port
  localparam int ADDR_W     = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [CFG_W-1:0]   CAPTURE_OFFSET_RST = 23'd256;
  localparam logic [CFG_W-1:0]   MAX_SPEED_RST      = 23'd256;
  localparam logic [COUNT_W-1:0] WAYPOINT_COUNT_RST = 5'd0;

  // datapath widths
  localparam int DELTA_W    = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int SQ_W       = PROD_W + 1;
  localparam int ROOT_STEPS = (SQ_W + 1) / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int RAD_W      = 2 * ROOT_STEPS;
  localparam int NUM_W      = PROD_W + 1;
  localparam int QUOT_W     = CFG_W;
  localparam int SUB_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  localparam int WAYPOINT_W = 2 * COORD_W + STATUS_W;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_POSITION = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_CAPTURE_OFFSET = 2'd0,
    REG_MAX_SPEED      = 2'd1,
    REG_WAYPOINT_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DELTA,
    S_ABS,
    S_CAPTURE,
    S_SQUARE_X,
    S_SQUARE_Y,
    S_SUM,
    S_ROOT_START,
    S_ROOT,
    S_MUL,
    S_NUMER,
    S_DIVIDE,
    S_SIGN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [STATUS_W-1:0] status;
  } waypoint_t;

endpackage

// ===== design/wfg_if.sv =====
// input channel: waypoint loads and position updates
interface wfg_cmd_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [wfg_pkg::SLOT_W-1:0]        slot;
  logic signed [wfg_pkg::COORD_W-1:0] coord_x;
  logic signed [wfg_pkg::COORD_W-1:0] coord_y;
  logic [wfg_pkg::STATUS_W-1:0]      point_status;

  modport source (
    output valid, operation, slot, coord_x, coord_y, point_status,
    input  ready
  );
  modport sink (
    input  valid, operation, slot, coord_x, coord_y, point_status,
    output ready
  );
endinterface

// output channel: commanded velocity and route status
interface wfg_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [wfg_pkg::COORD_W-1:0] velocity_x;
  logic signed [wfg_pkg::COORD_W-1:0] velocity_y;
  logic [wfg_pkg::STATUS_W-1:0]      target_status;
  logic [wfg_pkg::SLOT_W-1:0]        target_index;
  logic                              advanced;
  logic                              route_empty;

  modport source (
    output valid, velocity_x, velocity_y, target_status, target_index, advanced,
           route_empty,
    input  ready
  );
  modport sink (
    input  valid, velocity_x, velocity_y, target_status, target_index, advanced,
           route_empty,
    output ready
  );
endinterface

// ===== design/wfg_ram.sv =====
// single-port-write, single-port-read RAM with registered read data
module wfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/waypoint_follow_guidance.sv =====
// Waypoint-following guidance. The block holds a cyclic route of up to MAX_WAYPOINTS waypoints
// (x, y and an 8-bit status) in a small RAM, written by load transactions. A position
// transaction tests the position against a square capture box of half-width capture_offset
// (edges included) around the current waypoint, advances to the next waypoint on a hit, and
// returns a velocity of magnitude max_speed toward the current waypoint, rounded to nearest per
// axis, or zero at zero distance. One transaction is in work at a time and the input is not
// ready meanwhile; a finished result waits in the output register, so the next transaction can
// be taken before it is collected. One 24x24 multiplier forms the squares and the speed
// products, and one 28-bit subtractor runs the square root (one root bit a cycle) and then
// both divisions (one quotient bit a cycle). Waypoints read before they are loaded return
// undefined values.
`include "waypoint_follow_guidance_macros.svh"

module waypoint_follow_guidance #(
  parameter int MAX_WAYPOINTS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  wfg_cmd_if.sink                             cmd,
  wfg_rsp_if.source                           rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wfg_pkg::ADDR_W-1:0]          paddr,
  input  logic [wfg_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [wfg_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CNT_W = ($clog2(MAX_WAYPOINTS + 1) > wfg_pkg::COUNT_W) ?
                         $clog2(MAX_WAYPOINTS + 1) : wfg_pkg::COUNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WAYPOINTS);

  // configuration registers
  logic [wfg_pkg::CFG_W-1:0]   capture_offset;
  logic [wfg_pkg::CFG_W-1:0]   max_speed;
  logic [wfg_pkg::COUNT_W-1:0] waypoint_count;
  logic                        cfg_write;
  wfg_pkg::reg_idx_t           cfg_idx;

  // sequencer and datapath
  wfg_pkg::state_t             state;
  wfg_pkg::state_t             state_next;
  wfg_pkg::op_t                op;
  logic [IDX_W-1:0]            cur_idx;
  logic [wfg_pkg::COORD_W-1:0] pos_x;
  logic [wfg_pkg::COORD_W-1:0] pos_y;
  logic [wfg_pkg::DELTA_W-1:0] dx;
  logic [wfg_pkg::DELTA_W-1:0] dy;
  logic [wfg_pkg::MAG_W-1:0]   mag_x;
  logic [wfg_pkg::MAG_W-1:0]   mag_y;
  logic                        neg_x;
  logic                        neg_y;
  logic [wfg_pkg::STATUS_W-1:0] status_q;
  logic                        advanced_q;
  logic [wfg_pkg::PROD_W-1:0]  prod;
  logic [wfg_pkg::SQ_W-1:0]    d2;
  logic [wfg_pkg::RAD_W-1:0]   rad;
  logic [wfg_pkg::ROOT_W-1:0]  root;
  logic [wfg_pkg::SUB_W-1:0]   rem;
  logic [wfg_pkg::QUOT_W-1:0]  num_low;
  logic [wfg_pkg::QUOT_W-1:0]  quot;
  logic [wfg_pkg::STEP_W-1:0]  steps;
  logic                        axis;
  logic [wfg_pkg::COORD_W-1:0] vel_x;
  logic [wfg_pkg::COORD_W-1:0] vel_y;

  // output register
  logic                        out_valid;
  logic                        out_load;

  // combinational helpers
  logic                        cmd_fire;
  logic [CNT_W-1:0]            count_ext;
  logic [CNT_W-1:0]            eff_count;
  logic                        count_zero;
  logic                        idx_beyond;
  logic [CNT_W-1:0]            idx_inc;
  logic [IDX_W-1:0]            idx_wrap;
  logic                        capture_hit;
  logic                        slot_ok;
  logic                        steps_done;
  logic [wfg_pkg::MAG_W-1:0]   mul_a;
  logic [wfg_pkg::MAG_W-1:0]   mul_b;
  logic [wfg_pkg::PROD_W-1:0]  mul_out;
  logic [wfg_pkg::SUB_W-1:0]   sub_a;
  logic [wfg_pkg::SUB_W-1:0]   sub_b;
  logic [wfg_pkg::SUB_W:0]     sub_diff;
  logic                        sub_ok;
  logic [wfg_pkg::NUM_W-1:0]   numer;
  logic [wfg_pkg::COORD_W-1:0] signed_quot;
  logic                        ram_wr_en;
  logic                        ram_rd_en;
  wfg_pkg::waypoint_t          wp_wr;
  wfg_pkg::waypoint_t          wp_rd;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = wfg_pkg::reg_idx_t'(paddr[wfg_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_offset <= wfg_pkg::CAPTURE_OFFSET_RST;
      max_speed      <= wfg_pkg::MAX_SPEED_RST;
      waypoint_count <= wfg_pkg::WAYPOINT_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        wfg_pkg::REG_CAPTURE_OFFSET: capture_offset <= pwdata[wfg_pkg::CFG_W-1:0];
        wfg_pkg::REG_MAX_SPEED:      max_speed      <= pwdata[wfg_pkg::CFG_W-1:0];
        wfg_pkg::REG_WAYPOINT_COUNT: waypoint_count <= pwdata[wfg_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      wfg_pkg::REG_CAPTURE_OFFSET: prdata = wfg_pkg::APB_DATA_W'(capture_offset);
      wfg_pkg::REG_MAX_SPEED:      prdata = wfg_pkg::APB_DATA_W'(max_speed);
      wfg_pkg::REG_WAYPOINT_COUNT: prdata = wfg_pkg::APB_DATA_W'(waypoint_count);
      default:                     prdata = '0;
    endcase
  end

  // route length, clamped to the table size
  assign count_ext  = CNT_W'(waypoint_count);
  assign eff_count  = (count_ext > MAX_CNT) ? MAX_CNT : count_ext;
  assign count_zero = (eff_count == '0);
  assign idx_beyond = (CNT_W'(cur_idx) >= eff_count);
  assign idx_inc    = CNT_W'(cur_idx) + CNT_W'(1);
  assign idx_wrap   = (idx_inc >= eff_count) ? '0 : IDX_W'(idx_inc);

  assign cmd.ready = (state == wfg_pkg::S_IDLE);
  assign cmd_fire  = cmd.valid & cmd.ready;
  assign slot_ok   = (CNT_W'(cmd.slot) < MAX_CNT);

  // waypoint table
  assign ram_wr_en    = cmd_fire & (cmd.operation == wfg_pkg::OP_LOAD) & slot_ok;
  assign wp_wr.x      = cmd.coord_x;
  assign wp_wr.y      = cmd.coord_y;
  assign wp_wr.status = cmd.point_status;
  assign ram_rd_en    = (state == wfg_pkg::S_READ);

  wfg_ram #(
    .WIDTH (wfg_pkg::WAYPOINT_W),
    .DEPTH (MAX_WAYPOINTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (IDX_W'(cmd.slot)),
    .wr_data (wp_wr),
    .rd_en   (ram_rd_en),
    .rd_addr (cur_idx),
    .rd_data (wp_rd)
  );

  // shared multiplier: squares, then speed times axis magnitude
  always_comb begin
    mul_a = mag_x;
    mul_b = mag_x;
    if (state == wfg_pkg::S_MUL) begin
      mul_a = wfg_pkg::MAG_W'(max_speed);
      mul_b = axis ? mag_y : mag_x;
    end else if (state == wfg_pkg::S_SQUARE_Y) begin
      mul_a = mag_y;
      mul_b = mag_y;
    end
  end
  assign mul_out = mul_a * mul_b;

  // shared subtractor: square root digits, then restoring division steps
  always_comb begin
    if (state == wfg_pkg::S_ROOT) begin
      sub_a = {rem[wfg_pkg::SUB_W-3:0], rad[wfg_pkg::RAD_W-1 -: 2]};
      sub_b = wfg_pkg::SUB_W'({root, 2'b01});
    end else begin
      sub_a = {rem[wfg_pkg::SUB_W-2:0], num_low[wfg_pkg::QUOT_W-1]};
      sub_b = wfg_pkg::SUB_W'({root, 1'b0});
    end
  end
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ok   = ~sub_diff[wfg_pkg::SUB_W];

  // rounding numerator 2*speed*|d| + length
  assign numer = {prod, 1'b0} + wfg_pkg::NUM_W'(root);

  assign signed_quot = (axis ? neg_y : neg_x) ? -wfg_pkg::COORD_W'(quot)
                                              : wfg_pkg::COORD_W'(quot);

  assign capture_hit = (mag_x <= wfg_pkg::MAG_W'(capture_offset)) &&
                       (mag_y <= wfg_pkg::MAG_W'(capture_offset));
  assign steps_done  = (steps == '0);
  assign out_load    = (state == wfg_pkg::S_FINISH) & (~out_valid | rsp.ready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wfg_pkg::S_IDLE: begin
        if (cmd_fire) begin
          state_next = count_zero ? wfg_pkg::S_FINISH : wfg_pkg::S_READ;
        end
      end
      wfg_pkg::S_READ:       state_next = wfg_pkg::S_DELTA;
      wfg_pkg::S_DELTA: begin
        state_next = (op == wfg_pkg::OP_LOAD) ? wfg_pkg::S_FINISH : wfg_pkg::S_ABS;
      end
      wfg_pkg::S_ABS:        state_next = wfg_pkg::S_CAPTURE;
      wfg_pkg::S_CAPTURE: begin
        state_next = (capture_hit && !advanced_q) ? wfg_pkg::S_READ : wfg_pkg::S_SQUARE_X;
      end
      wfg_pkg::S_SQUARE_X:   state_next = wfg_pkg::S_SQUARE_Y;
      wfg_pkg::S_SQUARE_Y:   state_next = wfg_pkg::S_SUM;
      wfg_pkg::S_SUM:        state_next = wfg_pkg::S_ROOT_START;
      wfg_pkg::S_ROOT_START: begin
        state_next = (d2 == '0) ? wfg_pkg::S_FINISH : wfg_pkg::S_ROOT;
      end
      wfg_pkg::S_ROOT: begin
        if (steps_done) begin
          state_next = wfg_pkg::S_MUL;
        end
      end
      wfg_pkg::S_MUL:        state_next = wfg_pkg::S_NUMER;
      wfg_pkg::S_NUMER:      state_next = wfg_pkg::S_DIVIDE;
      wfg_pkg::S_DIVIDE: begin
        if (steps_done) begin
          state_next = wfg_pkg::S_SIGN;
        end
      end
      wfg_pkg::S_SIGN: begin
        state_next = axis ? wfg_pkg::S_FINISH : wfg_pkg::S_MUL;
      end
      wfg_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = wfg_pkg::S_IDLE;
        end
      end
      default:               state_next = wfg_pkg::S_IDLE;
    endcase
  end

  // current waypoint index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_idx <= '0;
    end else if (cmd_fire && (cmd.operation == wfg_pkg::OP_POSITION) && !count_zero &&
                 idx_beyond) begin
      cur_idx <= '0;
    end else if ((state == wfg_pkg::S_CAPTURE) && capture_hit && !advanced_q) begin
      cur_idx <= idx_wrap;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      wfg_pkg::S_IDLE: begin
        if (cmd_fire) begin
          op         <= wfg_pkg::op_t'(cmd.operation);
          pos_x      <= cmd.coord_x;
          pos_y      <= cmd.coord_y;
          advanced_q <= 1'b0;
          status_q   <= '0;
          vel_x      <= '0;
          vel_y      <= '0;
        end
      end
      wfg_pkg::S_DELTA: begin
        status_q <= wp_rd.status;
        dx <= {wp_rd.x[wfg_pkg::COORD_W-1], wp_rd.x} - {pos_x[wfg_pkg::COORD_W-1], pos_x};
        dy <= {wp_rd.y[wfg_pkg::COORD_W-1], wp_rd.y} - {pos_y[wfg_pkg::COORD_W-1], pos_y};
      end
      wfg_pkg::S_ABS: begin
        neg_x <= dx[wfg_pkg::DELTA_W-1];
        neg_y <= dy[wfg_pkg::DELTA_W-1];
        mag_x <= dx[wfg_pkg::DELTA_W-1] ? wfg_pkg::MAG_W'(-dx) : wfg_pkg::MAG_W'(dx);
        mag_y <= dy[wfg_pkg::DELTA_W-1] ? wfg_pkg::MAG_W'(-dy) : wfg_pkg::MAG_W'(dy);
      end
      wfg_pkg::S_CAPTURE: begin
        if (capture_hit && !advanced_q) begin
          advanced_q <= 1'b1;
        end
      end
      wfg_pkg::S_SQUARE_X: begin
        prod <= mul_out;
      end
      wfg_pkg::S_SQUARE_Y: begin
        d2   <= wfg_pkg::SQ_W'(prod);
        prod <= mul_out;
      end
      wfg_pkg::S_SUM: begin
        d2 <= d2 + wfg_pkg::SQ_W'(prod);
      end
      wfg_pkg::S_ROOT_START: begin
        rad   <= wfg_pkg::RAD_W'(d2);
        rem   <= '0;
        root  <= '0;
        steps <= wfg_pkg::STEP_W'(wfg_pkg::ROOT_STEPS - 1);
        axis  <= 1'b0;
      end
      wfg_pkg::S_ROOT: begin
        rem   <= sub_ok ? sub_diff[wfg_pkg::SUB_W-1:0] : sub_a;
        root  <= {root[wfg_pkg::ROOT_W-2:0], sub_ok};
        rad   <= {rad[wfg_pkg::RAD_W-3:0], 2'b00};
        steps <= steps - wfg_pkg::STEP_W'(1);
      end
      wfg_pkg::S_MUL: begin
        prod <= mul_out;
      end
      wfg_pkg::S_NUMER: begin
        rem     <= wfg_pkg::SUB_W'(numer[wfg_pkg::NUM_W-1:wfg_pkg::QUOT_W]);
        num_low <= numer[wfg_pkg::QUOT_W-1:0];
        steps   <= wfg_pkg::STEP_W'(wfg_pkg::QUOT_W - 1);
      end
      wfg_pkg::S_DIVIDE: begin
        rem     <= sub_ok ? sub_diff[wfg_pkg::SUB_W-1:0] : sub_a;
        quot    <= {quot[wfg_pkg::QUOT_W-2:0], sub_ok};
        num_low <= {num_low[wfg_pkg::QUOT_W-2:0], 1'b0};
        steps   <= steps - wfg_pkg::STEP_W'(1);
      end
      wfg_pkg::S_SIGN: begin
        if (axis) begin
          vel_y <= signed_quot;
        end else begin
          vel_x <= signed_quot;
        end
        axis <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.velocity_x    <= vel_x;
      rsp.velocity_y    <= vel_y;
      rsp.target_status <= count_zero ? '0 : status_q;
      rsp.target_index  <= wfg_pkg::SLOT_W'(cur_idx);
      rsp.advanced      <= advanced_q;
      rsp.route_empty   <= count_zero;
    end
  end

  assign rsp.valid = out_valid;

  // checks
  `WFG_ASSERT_NOW(a_quot_le_speed, clk, rst, state == wfg_pkg::S_SIGN, quot <= max_speed, "axis quotient above commanded speed")
  `WFG_ASSERT_NOW(a_root_floor, clk, rst, (state == wfg_pkg::S_MUL) && !axis, (wfg_pkg::RAD_W'(root) * wfg_pkg::RAD_W'(root) <= wfg_pkg::RAD_W'(d2)) && ((wfg_pkg::RAD_W'(root) + 1) * (wfg_pkg::RAD_W'(root) + 1) > wfg_pkg::RAD_W'(d2)), "square root is not the floor root")
  `WFG_ASSERT_NEXT(a_empty_zero_velocity, clk, rst, out_load && count_zero, rsp.route_empty && (rsp.velocity_x == '0) && (rsp.velocity_y == '0), "empty route gave nonzero velocity")
  `WFG_ASSERT_NOW(a_capture_position_only, clk, rst, state == wfg_pkg::S_CAPTURE, op == wfg_pkg::OP_POSITION, "capture test on a load transaction")

endmodule
